// ----- rtl/mexp_pkg.sv -----
// shared constants, types and state encodings for the modular exponentiation core
// no dependencies; imported by mexp_mulmod and modular_exponentiation_core
package mexp_pkg;

  localparam int unsigned EXP_WIDTH = 32;
  localparam int unsigned MOD_WIDTH = 32;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned EXP_W     = (EXP_WIDTH < DATA_W) ? EXP_WIDTH : DATA_W;
  localparam int unsigned PROD_W    = DATA_W + MOD_WIDTH;
  localparam int unsigned RED_STEPS = (PROD_W + 1) / 2;
  localparam int unsigned RED_W     = 2 * RED_STEPS;
  localparam int unsigned CNT_W     = $clog2(RED_STEPS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_BRED,
    S_STEP,
    S_MUL,
    S_ADV,
    S_SQR,
    S_FIN
  } seq_state_e;

  typedef enum logic [1:0] {
    U_IDLE,
    U_MUL,
    U_RED
  } unit_state_e;

  typedef struct packed {
    logic                 start;
    logic [DATA_W-1:0]    a;
    logic [MOD_WIDTH-1:0] b;
    logic [MOD_WIDTH-1:0] m;
  } mm_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [MOD_WIDTH-1:0] res;
  } mm_rsp_t;

endpackage

// ----- rtl/mexp_mulmod.sv -----
// shared modular multiply unit: registered product, then restoring remainder two bits a cycle
// depends on mexp_pkg
module mexp_mulmod import mexp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  mm_req_t req_i,
  output mm_rsp_t rsp_o
);

  unit_state_e          state_q, state_d;
  logic [CNT_W-1:0]     cnt_q;
  logic [DATA_W-1:0]    a_q;
  logic [MOD_WIDTH-1:0] b_q;
  logic [MOD_WIDTH-1:0] m_q;
  logic [RED_W-1:0]     div_q;
  logic [MOD_WIDTH-1:0] rem_q;
  logic [PROD_W-1:0]    prod;
  logic [MOD_WIDTH-1:0] rem_step1;
  logic [MOD_WIDTH-1:0] rem_step2;

  // one restoring step: bring in the next dividend bit, subtract once if needed
  function automatic logic [MOD_WIDTH-1:0] red_bit(input logic [MOD_WIDTH-1:0] r,
                                                   input logic                 nb,
                                                   input logic [MOD_WIDTH-1:0] m);
    logic [MOD_WIDTH:0] t;
    t = {r, nb};
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    return t[MOD_WIDTH-1:0];
  endfunction

  assign prod      = PROD_W'(a_q) * PROD_W'(b_q);
  assign rem_step1 = red_bit(rem_q, div_q[RED_W-1], m_q);
  assign rem_step2 = red_bit(rem_step1, div_q[RED_W-2], m_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      U_IDLE: begin
        if (req_i.start) begin
          state_d = U_MUL;
        end
      end
      U_MUL: begin
        state_d = U_RED;
      end
      U_RED: begin
        if (cnt_q == '0) begin
          state_d = U_IDLE;
        end
      end
      default: begin
        state_d = U_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_o.busy = (state_q != U_IDLE);
    rsp_o.done = (state_q == U_RED) && (cnt_q == '0);
    rsp_o.res  = rem_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == U_MUL) begin
        cnt_q <= CNT_W'(RED_STEPS);
      end else if (state_q == U_RED && cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == U_IDLE && req_i.start) begin
      a_q <= req_i.a;
      b_q <= req_i.b;
      m_q <= req_i.m;
    end
    if (state_q == U_MUL) begin
      div_q <= RED_W'(prod);
      rem_q <= '0;
    end else if (state_q == U_RED && cnt_q != '0) begin
      div_q <= div_q << 2;
      rem_q <= rem_step2;
    end
  end

endmodule

// ----- rtl/modular_exponentiation_core.sv -----
// modular exponentiation core: right-to-left square and multiply over one shared mulmod unit
// a zero exponent or zero modulus skips the mulmod unit; otherwise the run time grows with k,
// k = highest set exponent bit position plus one, and is shorter for each clear bit below it
// each modular product runs in the shared unit; one item at a time
// a finished item waits in the output register while the next item is taken
// rst_ni clears all control state asynchronously; no memories, no clearing pass
module modular_exponentiation_core import mexp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [DATA_W-1:0] base_i,
  input  logic [DATA_W-1:0] exponent_i,
  input  logic [DATA_W-1:0] modulus_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DATA_W-1:0] power_mod_o
);

  seq_state_e           state_q, state_d;
  logic [DATA_W-1:0]    base_q;
  logic [EXP_W-1:0]     e_q, e_d;
  logic [MOD_WIDTH-1:0] m_q;
  logic [MOD_WIDTH-1:0] acc_q, acc_d;
  logic [MOD_WIDTH-1:0] pw_q, pw_d;
  logic                 out_valid_q;
  logic [DATA_W-1:0]    power_mod_q;
  logic                 in_acc;
  logic                 out_load;
  logic [EXP_W-1:0]     e_next;
  mm_req_t              req;
  mm_rsp_t              rsp;

  mexp_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign power_mod_o = power_mod_q;
  assign e_next      = e_q >> 1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        if (e_q == '0 || m_q == '0) begin
          state_d = S_FIN;
        end else begin
          state_d = S_BRED;
        end
      end
      S_BRED: begin
        if (rsp.done) begin
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        state_d = e_q[0] ? S_MUL : S_ADV;
      end
      S_MUL: begin
        if (rsp.done) begin
          state_d = S_ADV;
        end
      end
      S_ADV: begin
        // last set bit handled: the final squaring is not needed
        state_d = (e_next == '0) ? S_FIN : S_SQR;
      end
      S_SQR: begin
        if (rsp.done) begin
          state_d = S_STEP;
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    req.start = 1'b0;
    req.a     = DATA_W'(pw_q);
    req.b     = pw_q;
    req.m     = m_q;
    acc_d     = acc_q;
    pw_d      = pw_q;
    e_d       = e_q;
    out_load  = 1'b0;
    case (state_q)
      S_LOAD: begin
        // zero modulus with nonzero exponent gives 0; zero exponent gives 1
        acc_d = (e_q != '0 && m_q == '0) ? '0 : MOD_WIDTH'(1);
        if (e_q != '0 && m_q != '0) begin
          // reduce the base once up front
          req.start = 1'b1;
          req.a     = base_q;
          req.b     = MOD_WIDTH'(1);
        end
      end
      S_BRED: begin
        if (rsp.done) begin
          pw_d = rsp.res;
        end
      end
      S_STEP: begin
        if (e_q[0]) begin
          req.start = 1'b1;
          req.a     = DATA_W'(acc_q);
          req.b     = pw_q;
        end
      end
      S_MUL: begin
        if (rsp.done) begin
          acc_d = rsp.res;
        end
      end
      S_ADV: begin
        e_d = e_next;
        if (e_next != '0) begin
          req.start = 1'b1;
        end
      end
      S_SQR: begin
        if (rsp.done) begin
          pw_d = rsp.res;
        end
      end
      S_FIN: begin
        out_load = !out_valid_q || !out_stall_i;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      base_q <= base_i;
      e_q    <= exponent_i[EXP_W-1:0];
      m_q    <= modulus_i[MOD_WIDTH-1:0];
    end else begin
      e_q <= e_d;
    end
    acc_q <= acc_d;
    pw_q  <= pw_d;
    if (out_load) begin
      power_mod_q <= DATA_W'(acc_q);
    end
  end

`ifndef SYNTH
  a_done_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> (state_q == S_BRED || state_q == S_MUL || state_q == S_SQR))
    else $error("mulmod result arrived while sequencer was not waiting");

  a_res_below_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> (rsp.res < m_q))
    else $error("mulmod result not reduced below modulus");

  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.start |-> !rsp.busy)
    else $error("mulmod started while busy");
`endif

endmodule
